// ===== rtl/scs_pkg.sv =====
// shared types and constants for the steering and collision smoother
package scs_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_MED       = 3'd1,
    ST_MUL_STEER = 3'd2,
    ST_MIX_HEAD  = 3'd3,
    ST_MUL_SPEED = 3'd4,
    ST_MIX_SPEED = 3'd5,
    ST_OUT       = 3'd6
  } state_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RUN_MODE     = 3'd0,
    CFG_SPEED_GAIN   = 3'd1,
    CFG_HEADING_GAIN = 3'd2,
    CFG_SPEED_LIMIT  = 3'd3,
    CFG_STEER_SPAN   = 3'd4,
    CFG_HOVER_HEIGHT = 3'd5
  } cfg_idx_t;

  localparam logic [1:0] MODE_FLYING   = 2'd1;
  localparam logic [1:0] MODE_STOPPING = 2'd2;

  localparam logic [8:0] GAIN_ONE = 9'd256;

  // serial multiply datapath widths
  localparam int ACC_W   = 35;
  localparam int MPL_A_W = 17;
  localparam int MPL_B_W = 9;

  typedef logic signed [ACC_W-1:0] acc_t;

  // rounding offsets loaded into the accumulator at the start of each product
  localparam acc_t RND_STEER = acc_t'(16384);
  localparam acc_t RND_MIX   = acc_t'(128);
  localparam acc_t RND_SPEED = acc_t'(32768);

  // reset values of the configuration registers
  localparam logic [8:0]  SPEED_GAIN_RST   = 9'd179;
  localparam logic [8:0]  HEADING_GAIN_RST = 9'd128;
  localparam logic [15:0] SPEED_LIMIT_RST  = 16'd13107;
  localparam logic [14:0] STEER_SPAN_RST   = 15'd15360;
  localparam logic [15:0] HOVER_HEIGHT_RST = 16'd77;

  function automatic logic [8:0] clamp_gain(input logic [8:0] g);
    clamp_gain = (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

  function automatic logic [15:0] median3(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      median3 = lo;
    end else if (c >= hi) begin
      median3 = hi;
    end else begin
      median3 = c;
    end
  endfunction

endpackage

// ===== rtl/steer_collision_smoother.sv =====
// steering and collision low-pass filter producing hover setpoints
// held or stop transactions go straight to the output state, a fresh flying one first runs
//   four bit-serial products; idle-mode ones produce no result; output stalls hold either
// one transaction in flight, the next is accepted only once the last has left the output state;
//   one multiplier bit per cycle from each shift register, ending early on zero upper bits
// reset (rst_n low, synchronous): config registers to defaults, ring, heading, speed cleared
module steer_collision_smoother (
  input  logic               clk,
  input  logic               rst_n,
  // input transaction channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_fresh,
  input  logic signed [15:0] in_steering,
  input  logic [15:0]        in_collision,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_halt,
  output logic [15:0]        out_forward_speed_out,
  output logic signed [15:0] out_yaw_rate,
  output logic [15:0]        out_height_out,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = scs_pkg::ACC_W;

  // configuration registers
  logic [1:0]  run_mode_r;
  logic [8:0]  speed_gain_r;
  logic [8:0]  heading_gain_r;
  logic [15:0] speed_limit_r;
  logic [14:0] steer_span_r;
  logic [15:0] hover_height_r;

  // filter state
  logic [15:0]        win_r [3];
  logic [1:0]         slot_r;
  logic signed [15:0] heading_r, heading_nxt;
  logic [15:0]        speed_r, speed_nxt;

  // sequencer
  scs_pkg::state_t state_r, state_nxt;

  // captured transaction
  logic signed [15:0] steer_r;
  logic [16:0]        comp_r, comp_nxt;     // 65536 minus the median collision

  // shift-add multiplier: two multiplier shift registers feed one accumulator
  scs_pkg::acc_t       acc_r, acc_nxt;
  scs_pkg::acc_t       cand_a_r, cand_a_nxt;
  scs_pkg::acc_t       cand_b_r, cand_b_nxt;
  logic [scs_pkg::MPL_A_W-1:0] mpl_a_r, mpl_a_nxt;
  logic [scs_pkg::MPL_B_W-1:0] mpl_b_r, mpl_b_nxt;

  scs_pkg::acc_t step_acc;
  logic          op_done;
  logic [15:0]   med;
  logic [8:0]    alpha, beta;
  logic [15:0]   head_tgt;
  logic [15:0]   speed_tgt;

  // result register
  logic               out_valid_r;
  logic               out_halt_r;
  logic [15:0]        out_speed_r;
  logic signed [15:0] out_yaw_r;
  logic [15:0]        out_height_r;

  logic in_acc;
  logic out_free;
  logic start_fresh;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != scs_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // only a fresh tick in flight runs the filters
  assign start_fresh = in_acc && (run_mode_r == scs_pkg::MODE_FLYING) && in_fresh;

  assign out_valid             = out_valid_r;
  assign out_halt              = out_halt_r;
  assign out_forward_speed_out = out_speed_r;
  assign out_yaw_rate          = out_yaw_r;
  assign out_height_out        = out_height_r;

  assign alpha = scs_pkg::clamp_gain(speed_gain_r);
  assign beta  = scs_pkg::clamp_gain(heading_gain_r);
  assign med   = scs_pkg::median3(win_r[0], win_r[1], win_r[2]);

  // one multiplier bit per cycle from each shift register
  assign step_acc = acc_r + (mpl_a_r[0] ? cand_a_r : '0) + (mpl_b_r[0] ? cand_b_r : '0);
  assign op_done  = (mpl_a_r == '0) && (mpl_b_r == '0);

  // finished products, floor-shifted by bit selection
  assign head_tgt  = acc_r[30:15];
  assign speed_tgt = acc_r[31:16];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (start_fresh) begin
            state_nxt = scs_pkg::ST_MED;
          end else if (run_mode_r == scs_pkg::MODE_FLYING ||
                       run_mode_r == scs_pkg::MODE_STOPPING) begin
            state_nxt = scs_pkg::ST_OUT;
          end
        end
      end
      scs_pkg::ST_MED:       state_nxt = scs_pkg::ST_MUL_STEER;
      scs_pkg::ST_MUL_STEER: if (op_done) state_nxt = scs_pkg::ST_MIX_HEAD;
      scs_pkg::ST_MIX_HEAD:  if (op_done) state_nxt = scs_pkg::ST_MUL_SPEED;
      scs_pkg::ST_MUL_SPEED: if (op_done) state_nxt = scs_pkg::ST_MIX_SPEED;
      scs_pkg::ST_MIX_SPEED: if (op_done) state_nxt = scs_pkg::ST_OUT;
      scs_pkg::ST_OUT:       if (out_free) state_nxt = scs_pkg::ST_IDLE;
      default:               state_nxt = scs_pkg::ST_IDLE;
    endcase
  end

  // datapath: shift the multiplier, or load the next product when one finishes
  always_comb begin
    acc_nxt     = step_acc;
    cand_a_nxt  = cand_a_r <<< 1;
    cand_b_nxt  = cand_b_r <<< 1;
    mpl_a_nxt   = mpl_a_r >> 1;
    mpl_b_nxt   = mpl_b_r >> 1;
    comp_nxt    = comp_r;
    heading_nxt = heading_r;
    speed_nxt   = speed_r;
    unique case (state_r)
      scs_pkg::ST_MED: begin
        // steer_span times steering
        comp_nxt   = 17'h10000 - {1'b0, med};
        acc_nxt    = scs_pkg::RND_STEER;
        mpl_a_nxt  = {2'b00, steer_span_r};
        cand_a_nxt = {{(AW-16){steer_r[15]}}, steer_r};
        mpl_b_nxt  = '0;
        cand_b_nxt = '0;
      end
      scs_pkg::ST_MUL_STEER: begin
        if (op_done) begin
          // heading blend: (1 - beta) * heading + beta * target
          acc_nxt    = scs_pkg::RND_MIX;
          mpl_a_nxt  = {8'd0, 9'(scs_pkg::GAIN_ONE - beta)};
          cand_a_nxt = {{(AW-16){heading_r[15]}}, heading_r};
          mpl_b_nxt  = beta;
          cand_b_nxt = {{(AW-16){head_tgt[15]}}, head_tgt};
        end
      end
      scs_pkg::ST_MIX_HEAD: begin
        if (op_done) begin
          heading_nxt = acc_r[23:8];
          // speed target: (1 - collision) times speed limit
          acc_nxt    = scs_pkg::RND_SPEED;
          mpl_a_nxt  = comp_r;
          cand_a_nxt = {{(AW-16){1'b0}}, speed_limit_r};
          mpl_b_nxt  = '0;
          cand_b_nxt = '0;
        end
      end
      scs_pkg::ST_MUL_SPEED: begin
        if (op_done) begin
          // speed blend: (1 - alpha) * speed + alpha * target
          acc_nxt    = scs_pkg::RND_MIX;
          mpl_a_nxt  = {8'd0, 9'(scs_pkg::GAIN_ONE - alpha)};
          cand_a_nxt = {{(AW-16){1'b0}}, speed_r};
          mpl_b_nxt  = alpha;
          cand_b_nxt = {{(AW-16){1'b0}}, speed_tgt};
        end
      end
      scs_pkg::ST_MIX_SPEED: begin
        if (op_done) begin
          speed_nxt = acc_r[23:8];
        end
      end
      default: begin
      end
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= scs_pkg::ST_IDLE;
      out_valid_r    <= 1'b0;
      run_mode_r     <= '0;
      speed_gain_r   <= scs_pkg::SPEED_GAIN_RST;
      heading_gain_r <= scs_pkg::HEADING_GAIN_RST;
      speed_limit_r  <= scs_pkg::SPEED_LIMIT_RST;
      steer_span_r   <= scs_pkg::STEER_SPAN_RST;
      hover_height_r <= scs_pkg::HOVER_HEIGHT_RST;
      win_r[0]       <= '0;
      win_r[1]       <= '0;
      win_r[2]       <= '0;
      slot_r         <= '0;
      heading_r      <= '0;
      speed_r        <= '0;
    end else begin
      state_r   <= state_nxt;
      heading_r <= heading_nxt;
      speed_r   <= speed_nxt;

      // configuration writes, indexes past the list are dropped
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          scs_pkg::CFG_RUN_MODE:     run_mode_r     <= cfg_data[1:0];
          scs_pkg::CFG_SPEED_GAIN:   speed_gain_r   <= cfg_data[8:0];
          scs_pkg::CFG_HEADING_GAIN: heading_gain_r <= cfg_data[8:0];
          scs_pkg::CFG_SPEED_LIMIT:  speed_limit_r  <= cfg_data;
          scs_pkg::CFG_STEER_SPAN:   steer_span_r   <= cfg_data[14:0];
          scs_pkg::CFG_HOVER_HEIGHT: hover_height_r <= cfg_data;
          default: begin
          end
        endcase
      end

      // nonzero collision of a fresh flying tick goes into the ring, slot steps 0, 1, 2 and wraps
      if (start_fresh && (in_collision != '0)) begin
        win_r[slot_r] <= in_collision;
        slot_r        <= (slot_r == 2'd2) ? 2'd0 : 2'(slot_r + 2'd1);
      end

      if (state_r == scs_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    cand_a_r <= cand_a_nxt;
    cand_b_r <= cand_b_nxt;
    mpl_a_r  <= mpl_a_nxt;
    mpl_b_r  <= mpl_b_nxt;
    comp_r   <= comp_nxt;
    if (in_acc) begin
      steer_r <= in_steering;
    end
    if (state_r == scs_pkg::ST_OUT && out_free) begin
      if (run_mode_r == scs_pkg::MODE_STOPPING) begin
        // stop command carries all-zero setpoints
        out_halt_r   <= 1'b1;
        out_speed_r  <= '0;
        out_yaw_r    <= '0;
        out_height_r <= '0;
      end else begin
        out_halt_r   <= 1'b0;
        out_speed_r  <= speed_r;
        out_yaw_r    <= heading_r;
        out_height_r <= hover_height_r;
      end
    end
  end

endmodule

// ===== tb/steer_collision_smoother_tb.sv =====
// self-checking testbench for the steering and collision smoother
module steer_collision_smoother_tb;

  // one control tick as queued for the driver
  typedef struct {
    logic               fresh;
    logic signed [15:0] steer;
    logic [15:0]        coll;
  } tick_t;

  // one hover or stop setpoint as seen on the result channel
  typedef struct packed {
    logic               halt;
    logic [15:0]        speed;
    logic signed [15:0] yaw;
    logic [15:0]        height;
  } hover_cmd_t;

  localparam int CYCLE_LIMIT   = 800000;  // several times the slowest legal run
  localparam int SETTLE_CYCLES = 80;      // covers the longest fresh flying transaction
  localparam int RANDOM_TICKS  = 1150;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_fresh = 1'b0;
  logic signed [15:0] in_steering = '0;
  logic [15:0]        in_collision = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_halt;
  logic [15:0]        out_forward_speed_out;
  logic signed [15:0] out_yaw_rate;
  logic [15:0]        out_height_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  steer_collision_smoother u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_fresh              (in_fresh),
    .in_steering           (in_steering),
    .in_collision          (in_collision),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_halt              (out_halt),
    .out_forward_speed_out (out_forward_speed_out),
    .out_yaw_rate          (out_yaw_rate),
    .out_height_out        (out_height_out),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirrored configuration, updated on every accepted config write
  logic [1:0]  mode_q;
  logic [8:0]  speed_gain_q;
  logic [8:0]  heading_gain_q;
  logic [15:0] speed_limit_q;
  logic [14:0] steer_span_q;
  logic [15:0] hover_height_q;

  // mirrored filter state
  logic [15:0] coll_ring [3];
  int          ring_slot;
  int          heading_q;
  int          speed_q;

  tick_t      pending_ticks[$];
  hover_cmd_t expected_setpoints[$];
  tick_t      next_tick;

  int  ticks_queued = 0;
  int  ticks_accepted = 0;
  int  errors = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  idling = 1'b1;  // cleared for quiet phases with back-to-back traffic

  // idle length: mostly drawn from the short range, now and then a long pause
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] mid_of_three(input logic [15:0] a, input logic [15:0] b,
                                               input logic [15:0] c);
    if (a > b) begin
      return (b > c) ? b : ((a > c) ? c : a);
    end
    return (a > c) ? a : ((b > c) ? c : b);
  endfunction

  // advance the mirrored filter by one accepted tick and queue its setpoint
  task automatic predict_setpoint(input logic fresh, input logic signed [15:0] steer,
                                  input logic [15:0] coll);
    hover_cmd_t  sp;
    logic [15:0] med;
    int          ia;
    int          ib;
    longint      target;
    longint      acc;
    longint      vt;
    longint      vacc;
    sp = '0;
    if (mode_q == scs_pkg::MODE_FLYING) begin
      if (fresh) begin
        // zero collision is not recorded into the ring
        if (coll != 16'd0) begin
          coll_ring[ring_slot] = coll;
          ring_slot = (ring_slot == 2) ? 0 : ring_slot + 1;
        end
        med = mid_of_three(coll_ring[0], coll_ring[1], coll_ring[2]);
        // gains above one saturate at one
        ib = (heading_gain_q > 9'd256) ? 256 : int'(heading_gain_q);
        ia = (speed_gain_q > 9'd256) ? 256 : int'(speed_gain_q);
        target = (longint'(steer_span_q) * longint'(steer) + 16384) >>> 15;
        acc = longint'(256 - ib) * longint'(heading_q) + longint'(ib) * target + 128;
        heading_q = int'(acc >>> 8);
        vt = (longint'(65536 - int'(med)) * longint'(speed_limit_q) + 32768) >>> 16;
        vacc = longint'(256 - ia) * longint'(speed_q) + longint'(ia) * vt + 128;
        speed_q = int'((vacc >>> 8) & 64'hFFFF);
      end
      // stale ticks emit the held heading and speed
      sp.speed  = speed_q[15:0];
      sp.yaw    = heading_q[15:0];
      sp.height = hover_height_q;
      expected_setpoints.push_back(sp);
    end else if (mode_q == scs_pkg::MODE_STOPPING) begin
      sp.halt = 1'b1;
      expected_setpoints.push_back(sp);
    end
    // idle and the unused mode three emit nothing
  endtask

  task automatic report(input string name, input logic [15:0] exp_v, input logic [15:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
  endtask

  // input driver: takes ticks from the pending queue, holds them while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ticks.size() > 0) begin
        next_tick = pending_ticks.pop_front();
        in_valid     <= 1'b1;
        in_fresh     <= next_tick.fresh;
        in_steering  <= next_tick.steer;
        in_collision <= next_tick.coll;
        gap_left     <= (idling && $urandom_range(0, 99) < 35) ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side backpressure, independent of out_valid
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 99) < 20) begin
      out_stall  <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: config mirror, prediction on accepted input, check on accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (scs_pkg::cfg_idx_t'(cfg_index))
          scs_pkg::CFG_RUN_MODE:     mode_q         = cfg_data[1:0];
          scs_pkg::CFG_SPEED_GAIN:   speed_gain_q   = cfg_data[8:0];
          scs_pkg::CFG_HEADING_GAIN: heading_gain_q = cfg_data[8:0];
          scs_pkg::CFG_SPEED_LIMIT:  speed_limit_q  = cfg_data;
          scs_pkg::CFG_STEER_SPAN:   steer_span_q   = cfg_data[14:0];
          scs_pkg::CFG_HOVER_HEIGHT: hover_height_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_setpoint(in_fresh, in_steering, in_collision);
        ticks_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (expected_setpoints.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction, expected none, actual %b %h %h %h",
                   $time, out_halt, out_forward_speed_out, out_yaw_rate, out_height_out);
        end else begin
          hover_cmd_t sp;
          sp = expected_setpoints.pop_front();
          if (sp.halt !== out_halt) report("halt", 16'(sp.halt), 16'(out_halt));
          if (sp.speed !== out_forward_speed_out) begin
            report("forward_speed_out", sp.speed, out_forward_speed_out);
          end
          if (sp.yaw !== out_yaw_rate) report("yaw_rate", sp.yaw, out_yaw_rate);
          if (sp.height !== out_height_out) report("height_out", sp.height, out_height_out);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("steer_collision_smoother_tb: FAIL");
      $finish;
    end
  end

  task automatic queue_tick(input logic fresh, input logic signed [15:0] steer,
                            input logic [15:0] coll);
    tick_t t;
    t.fresh = fresh;
    t.steer = steer;
    t.coll  = coll;
    pending_ticks.push_back(t);
    ticks_queued++;
  endtask

  // sender holds off until every transaction is through, then the block drains
  task automatic settle();
    @(posedge clk);
    while (ticks_accepted != ticks_queued || expected_setpoints.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input scs_pkg::cfg_idx_t idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] mode, input logic [15:0] sg,
                               input logic [15:0] hg, input logic [15:0] lim,
                               input logic [15:0] span, input logic [15:0] hov);
    write_reg(scs_pkg::CFG_SPEED_GAIN, sg);
    write_reg(scs_pkg::CFG_HEADING_GAIN, hg);
    write_reg(scs_pkg::CFG_SPEED_LIMIT, lim);
    write_reg(scs_pkg::CFG_STEER_SPAN, span);
    write_reg(scs_pkg::CFG_HOVER_HEIGHT, hov);
    write_reg(scs_pkg::CFG_RUN_MODE, mode);
  endtask

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'd0;
      1: return 16'd256;
      2: return 16'd511;
      3: return 16'd257;
      default: return 16'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [15:0] pick_wide(input logic [15:0] top);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return top;
    return 16'($urandom);
  endfunction

  task automatic random_tick();
    logic               fresh;
    logic signed [15:0] steer;
    logic [15:0]        coll;
    int                 r;
    fresh = ($urandom_range(0, 99) < 75);
    r = $urandom_range(0, 9);
    steer = (r == 0) ? 16'sh7FFF : ((r == 1) ? 16'sh8000 : 16'($urandom));
    r = $urandom_range(0, 9);
    if (r < 2) begin
      coll = 16'd0;
    end else if (r == 2) begin
      coll = 16'hFFFF;
    end else if (r == 3) begin
      coll = 16'd1;
    end else begin
      coll = 16'($urandom);
    end
    queue_tick(fresh, steer, coll);
  endtask

  initial begin
    int counted;
    int n;
    int r;
    logic [15:0] mode;

    // mirror starts at the reset state of the block
    mode_q         = 2'd0;
    speed_gain_q   = scs_pkg::SPEED_GAIN_RST;
    heading_gain_q = scs_pkg::HEADING_GAIN_RST;
    speed_limit_q  = scs_pkg::SPEED_LIMIT_RST;
    steer_span_q   = scs_pkg::STEER_SPAN_RST;
    hover_height_q = scs_pkg::HOVER_HEIGHT_RST;
    coll_ring[0] = '0;
    coll_ring[1] = '0;
    coll_ring[2] = '0;
    ring_slot = 0;
    heading_q = 0;
    speed_q   = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // idle after reset: ticks change nothing and produce nothing
    queue_tick(1'b1, 16'sh7FFF, 16'hFFFF);
    queue_tick(1'b1, 16'sh8000, 16'd1);
    settle();

    // flying with default gains: zero collision, steering extremes, stale ticks, ring wrap
    write_reg(scs_pkg::CFG_RUN_MODE, 16'(scs_pkg::MODE_FLYING));
    queue_tick(1'b1, 16'sh0000, 16'd0);
    queue_tick(1'b1, 16'sh7FFF, 16'd0);
    queue_tick(1'b1, 16'sh8000, 16'hFFFF);
    queue_tick(1'b0, 16'sd12345, 16'd40000);
    queue_tick(1'b1, 16'sd16384, 16'd1);
    queue_tick(1'b1, -16'sd1, 16'd30000);
    queue_tick(1'b1, 16'sh0000, 16'hFFFF);
    queue_tick(1'b1, 16'sh7FFF, 16'd20000);
    queue_tick(1'b0, 16'sh8000, 16'd0);
    queue_tick(1'b1, 16'sh8000, 16'd0);
    settle();

    // stopping: all-zero command, fresh tick must not move the filter
    write_reg(scs_pkg::CFG_RUN_MODE, 16'(scs_pkg::MODE_STOPPING));
    queue_tick(1'b1, 16'sh7FFF, 16'hFFFF);
    queue_tick(1'b0, 16'sh0000, 16'd0);
    settle();

    // unused mode three behaves as idle
    write_reg(scs_pkg::CFG_RUN_MODE, 16'd3);
    queue_tick(1'b1, 16'sd1, 16'd1);
    settle();

    // gains above one, maximum limits, span written with its unused top bit set
    apply_setting(16'(scs_pkg::MODE_FLYING), 16'd511, 16'd257, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_tick(1'b1, 16'sh8000, 16'hFFFF);
    queue_tick(1'b1, 16'sh7FFF, 16'd1);
    queue_tick(1'b0, 16'sh0000, 16'd0);
    settle();

    // all-zero settings: filters frozen
    apply_setting(16'(scs_pkg::MODE_FLYING), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_tick(1'b1, 16'sh7FFF, 16'hFFFF);
    queue_tick(1'b1, 16'sh8000, 16'd1);
    settle();

    // unity gains: filters follow the target at once
    apply_setting(16'(scs_pkg::MODE_FLYING), 16'd256, 16'd256, 16'd50000, 16'd32767,
                  16'd1280);
    queue_tick(1'b1, 16'sh7FFF, 16'd50000);
    queue_tick(1'b1, 16'sh8000, 16'd2);
    settle();

    // random phases, each with its own setting; some phases run without idling
    counted = 0;
    while (counted < RANDOM_TICKS) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        mode = 16'(scs_pkg::MODE_FLYING);
      end else if (r < 88) begin
        mode = 16'(scs_pkg::MODE_STOPPING);
      end else if (r < 95) begin
        mode = 16'd0;
      end else begin
        mode = 16'd3;
      end
      // a few writes carry garbage in the unused upper bits
      if ($urandom_range(0, 3) == 0) mode = mode | (16'($urandom) & 16'hFFFC);
      apply_setting(mode, pick_gain(), pick_gain(), pick_wide(16'hFFFF),
                    pick_wide(16'h7FFF), pick_wide(16'hFFFF));
      idling = ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 120);
      repeat (n) random_tick();
      counted += n;
      settle();
    end

    idling = 1'b1;
    if (expected_setpoints.size() != 0) begin
      errors++;
      $display("%0t: %0d expected result transactions never arrived", $time,
               expected_setpoints.size());
    end
    if (errors == 0) begin
      $display("steer_collision_smoother_tb: PASS");
    end else begin
      $display("steer_collision_smoother_tb: FAIL");
    end
    $finish;
  end

endmodule
